FILE: hw/rtl/nrta_pkg.sv
// Shared types and constants for the neighbor range table with aging.
// Holds the request mode codes, stream field widths and the table entry layout.
// No dependencies; imported by every module of the block but nrta_ram.
`default_nettype none

package nrta_pkg;

   // request modes carried on req_tuser
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SWEEP = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam int MODE_W    = 2;
   localparam int ID_W      = 8;
   localparam int MM_W      = 20;
   localparam int STAMP_W   = 32;
   localparam int LIMIT_W   = 16;
   localparam int COUNT_W   = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // stream widths; the data widths are padded to whole bytes
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 2;

   // one table entry as stored in the entry RAM
   typedef struct packed {
      logic signed [MM_W-1:0] rel_z;
      logic signed [MM_W-1:0] rel_y;
      logic signed [MM_W-1:0] rel_x;
      logic [MM_W-1:0]        range_mm;
      logic [STAMP_W-1:0]     stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: hw/rtl/nrta_ram.sv
// Generic single-port RAM with registered read data.
// Used for the neighbor entry storage; no dependencies.
`default_nettype none

module nrta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
   input  wire logic [WIDTH-1:0]                              wdata,
   output logic      [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write on request, register the read word every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/nrta_age_cmp.sv
// Shared age compare unit: age = now - stamp (modulo 2^32), flag when above limit.
// Depends on nrta_pkg for widths.
`default_nettype none

module nrta_age_cmp (
   input  wire logic [nrta_pkg::STAMP_W-1:0] now_ms,
   input  wire logic [nrta_pkg::STAMP_W-1:0] stamp,
   input  wire logic [nrta_pkg::LIMIT_W-1:0] limit_ms,
   output logic                              expired
);
   import nrta_pkg::*;

   logic [STAMP_W-1:0] age;

   // wrapping subtract, then one wide compare against the zero-extended limit
   always_comb begin
      age     = now_ms - stamp;
      expired = age > {{(STAMP_W-LIMIT_W){1'b0}}, limit_ms};
   end

endmodule

`default_nettype wire

FILE: hw/rtl/neighbor_range_table_aging.sv
// Neighbor range table with aging. One item at a time; a result word is held
// in an output register. Tick, write and rejected ids load that register at the
// accept; a query waits in ST_QUERY for the RAM word, and a sweep walks the entry
// RAM through the shared age compare, one entry a cycle, then ends in ST_SWEEP_END.
// A new request is taken only when idle and the output register is free.
// Reset (synchronous) clears valid marks, clock and count; RAM contents are kept.
`default_nettype none

module neighbor_range_table_aging #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: peer_id[7:0], range_mm[27:8], rel_x_mm[47:28],
   //            rel_y_mm[67:48], rel_z_mm[87:68]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [nrta_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: mode[1:0]
   input  wire logic [nrta_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata: out_range_mm[19:0], out_x[39:20], out_y[59:40], out_z[79:60],
   //            live_count[84:80], zero[87:85]
   output logic      [nrta_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: hit[0], bad_id[1]
   output logic      [nrta_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [nrta_pkg::LIMIT_W-1:0]     csr_wdata
);
   import nrta_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_QUERY     = 2'd1;
   localparam logic [1:0] ST_SWEEP     = 2'd2;
   localparam logic [1:0] ST_SWEEP_END = 2'd3;

   // control state
   logic [1:0]               state_ff, state_in;
   logic [STAMP_W-1:0]       clock_ms_ff, clock_ms_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]       total_ff, total_in;
   logic [COUNT_W-1:0]       sweep_cnt_ff, sweep_cnt_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     q_hit_ff, q_hit_in;
   logic [LIMIT_W-1:0]       limit_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   // result payload
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]    rsp_user_ff, rsp_user_in;

   // request fields
   logic [MODE_W-1:0]        req_mode;
   logic [ID_W-1:0]          req_id;
   logic                     id_ok;
   logic                     req_fire;
   logic                     out_free;

   // RAM and compare unit signals
   logic                     ram_we;
   logic [IDX_W-1:0]         ram_addr;
   entry_type                ram_wdata;
   entry_type                ram_rdata;
   logic                     expired;
   logic                     keep;

   assign req_mode = req_tuser[MODE_W-1:0];
   assign req_id   = req_tdata[ID_W-1:0];
   assign id_ok    = {1'b0, req_id} < (ID_W+1)'(TABLE_ENTRIES);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // entry word for a write
   always_comb begin
      ram_wdata.stamp    = clock_ms_ff;
      ram_wdata.range_mm = req_tdata[27:8];
      ram_wdata.rel_x    = req_tdata[47:28];
      ram_wdata.rel_y    = req_tdata[67:48];
      ram_wdata.rel_z    = req_tdata[87:68];
   end

   assign ram_we   = req_fire && (req_mode == MODE_WRITE) && id_ok;
   assign ram_addr = (state_ff == ST_SWEEP) ? issue_ff[IDX_W-1:0] : req_id[IDX_W-1:0];

   nrta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   nrta_age_cmp u_age (
      .now_ms   (clock_ms_ff),
      .stamp    (ram_rdata.stamp),
      .limit_ms (limit_ff),
      .expired  (expired)
   );

   assign keep = valid_ff[chk_idx_ff] && !expired;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clock_ms_in  = clock_ms_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      sweep_cnt_in = sweep_cnt_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      q_hit_in     = q_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // immediate result unless overridden below
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[84:80] = total_ff;
               rsp_user_in  = '0;
               case (req_mode)
                  MODE_TICK: begin
                     clock_ms_in = clock_ms_ff + 1'b1;
                  end
                  MODE_SWEEP: begin
                     rsp_valid_in = 1'b0;
                     issue_in     = '0;
                     sweep_cnt_in = '0;
                     state_in     = ST_SWEEP;
                  end
                  MODE_WRITE: begin
                     if (id_ok) begin
                        valid_in[req_id[IDX_W-1:0]] = 1'b1;
                        rsp_user_in[0] = 1'b1;
                     end else begin
                        rsp_user_in[1] = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     if (id_ok) begin
                        rsp_valid_in = 1'b0;
                        q_hit_in     = valid_ff[req_id[IDX_W-1:0]];
                        state_in     = ST_QUERY;
                     end else begin
                        rsp_user_in[1] = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_QUERY: begin
            // RAM word arrived; present it on a hit, zeros on a miss
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[84:80] = total_ff;
               rsp_user_in  = '0;
               if (q_hit_ff) begin
                  rsp_data_in[19:0]  = ram_rdata.range_mm;
                  rsp_data_in[39:20] = ram_rdata.rel_x;
                  rsp_data_in[59:40] = ram_rdata.rel_y;
                  rsp_data_in[79:60] = ram_rdata.rel_z;
                  rsp_user_in[0]     = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // issue one read per cycle, check the entry read the cycle before
            if (issue_ff != CNT_W'(TABLE_ENTRIES)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (!keep) begin
                  valid_in[chk_idx_ff] = 1'b0;
               end
               if (keep && (sweep_cnt_ff != COUNT_MAX)) begin
                  sweep_cnt_in = sweep_cnt_ff + 1'b1;
               end
               if (issue_ff == CNT_W'(TABLE_ENTRIES)) begin
                  state_in = ST_SWEEP_END;
               end
            end
         end
         ST_SWEEP_END: begin
            if (out_free) begin
               total_in     = sweep_cnt_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[84:80] = sweep_cnt_ff;
               rsp_user_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ms_ff  <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         sweep_cnt_ff <= '0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         chk_idx_ff   <= '0;
         q_hit_ff     <= 1'b0;
         limit_ff     <= LIMIT_W'(1000);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ms_ff  <= clock_ms_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         sweep_cnt_ff <= sweep_cnt_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         chk_idx_ff   <= chk_idx_in;
         q_hit_ff     <= q_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/nrta_checker.sv
// Port-level checks for the neighbor range table, bound to the top level.
// Depends on nrta_pkg for stream widths.
`default_nettype none

module nrta_checker #(
   parameter int TABLE_ENTRIES = 16
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [nrta_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic [nrta_pkg::REQ_USER_W-1:0]  req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [nrta_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [nrta_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import nrta_pkg::*;

   localparam int CNT_CAP = (TABLE_ENTRIES > 31) ? 31 : TABLE_ENTRIES;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // hit and rejected id never come together
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("hit and bad_id both set");

   // a word without a hit carries zero data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[79:0] == '0)
      else $error("data nonzero without hit");

   // neighbor count within table size and at most 31
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[84:80] <= COUNT_W'(CNT_CAP))
      else $error("neighbor count above table size");

   // one item at a time: no new accept right after an accept of a sweep or of a query with a valid id
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_SWEEP || req_tuser == MODE_QUERY)
         && (req_tdata[7:0] < 8'(TABLE_ENTRIES) || req_tuser == MODE_SWEEP)
      |=> !req_tready)
      else $error("request taken while an item is in progress");

endmodule

bind neighbor_range_table_aging nrta_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (.*);

`default_nettype wire
